@@ rtl/ssht_pkg.sv @@
`default_nettype none
package ssht_pkg;

    localparam int SLOTS_DEF  = 64;
    localparam int NAME_DEF   = 32;
    localparam int SCOPES_DEF = 8;

    localparam logic [31:0] HASH_SEED = 32'd5381;
    localparam logic [15:0] NO_INDEX  = 16'hFFFF;

    typedef enum logic [1:0] {
        K_INSERT = 2'd0,
        K_LOOKUP = 2'd1,
        K_PUSH   = 2'd2,
        K_POP    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NOT_FOUND   = 3'd1,
        ST_TOO_LONG    = 3'd2,
        ST_TABLE_FULL  = 3'd3,
        ST_STACK_FULL  = 3'd4,
        ST_STACK_EMPTY = 3'd5
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic    key_upd;
        logic    probe_init;
        logic    cnt_init;
        logic    meta_rd;
        logic    meta_ins;
        logic    meta_clr;
        logic    cnt_adv;
        logic    j_clr;
        logic    j_inc;
        logic    name_rd;
        logic    name_wr;
        logic    depth_inc;
        logic    depth_dec;
        logic    key_clr;
        logic    out_load;
        logic    out_found;
        t_status out_status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic len_full;
        logic depth_zero;
        logic depth_full;
        logic slot_used;
        logic len_match;
        logic len_zero;
        logic byte_match;
        logic j_last;
        logic cnt_last;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

@@ rtl/ssht_ram.sv @@
`default_nettype none
module ssht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

@@ rtl/ssht_dp.sv @@
`default_nettype none
module ssht_dp #(
    parameter int SLOTS  = ssht_pkg::SLOTS_DEF,
    parameter int NAME   = ssht_pkg::NAME_DEF,
    parameter int SCOPES = ssht_pkg::SCOPES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ssht_pkg::t_cmd i_cmd,
    output ssht_pkg::t_sts      o_sts,
    input  wire logic [7:0]     i_key_byte,
    input  wire logic [15:0]    i_sym_index,
    input  wire logic [3:0]     i_sym_type,
    input  wire logic           i_out_ready,
    output logic                o_out_valid,
    output logic [23:0]         o_out_data
);
    import ssht_pkg::*;

    localparam int SB = $clog2(SLOTS);
    localparam int NB = $clog2(NAME);
    localparam int LW = $clog2(NAME + 1);
    localparam int DB = $clog2(SCOPES);
    localparam int DW = $clog2(SCOPES + 1);
    localparam int MW = 1 + LW + 16 + 4;
    localparam int MD = SCOPES * SLOTS;
    localparam int ND = MD * (2 ** NB);

    logic [7:0]    r_kb [NAME];
    logic [LW-1:0] r_len;
    logic [31:0]   r_hash;
    logic [15:0]   r_idx;
    logic [3:0]    r_type;
    logic [SB-1:0] r_ptr;
    logic [SB-1:0] r_cnt;
    logic [NB-1:0] r_j;
    logic [DW-1:0] r_depth;
    logic          r_out_valid;
    t_status       r_out_status;
    logic [15:0]   r_out_found;

    logic [DB-1:0]       w_top;
    logic [DB+SB-1:0]    w_meta_addr;
    logic [MW-1:0]       w_meta_wdata;
    logic [MW-1:0]       w_meta_rdata;
    logic [DB+SB+NB-1:0] w_name_addr;
    logic [7:0]          w_name_rdata;

    assign w_top        = DB'(r_depth - DW'(1));
    assign w_meta_addr  = {(i_cmd.meta_clr ? r_depth[DB-1:0] : w_top), r_ptr};
    assign w_meta_wdata = i_cmd.meta_clr ? '0 : {1'b1, r_len, r_idx, r_type};
    assign w_name_addr  = {w_top, r_ptr, r_j};

    ssht_ram #(.WIDTH(MW), .DEPTH(MD)) u_meta (
        .i_clk  (i_clk),
        .i_we   (i_cmd.meta_ins | i_cmd.meta_clr),
        .i_waddr(w_meta_addr),
        .i_wdata(w_meta_wdata),
        .i_re   (i_cmd.meta_rd),
        .i_raddr(w_meta_addr),
        .o_rdata(w_meta_rdata)
    );

    ssht_ram #(.WIDTH(8), .DEPTH(ND)) u_name (
        .i_clk  (i_clk),
        .i_we   (i_cmd.name_wr),
        .i_waddr(w_name_addr),
        .i_wdata(r_kb[r_j]),
        .i_re   (i_cmd.name_rd),
        .i_raddr(w_name_addr),
        .o_rdata(w_name_rdata)
    );

    // name buffer and hash
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_hash <= HASH_SEED;
        end else if (i_cmd.key_clr) begin
            r_len  <= '0;
            r_hash <= HASH_SEED;
        end else if (i_cmd.key_upd) begin
            if (r_len < LW'(NAME)) begin
                r_len <= r_len + LW'(1);
            end
            r_hash <= (r_hash << 5) + r_hash + {24'd0, i_key_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_upd) begin
            if (r_len < LW'(NAME)) begin
                r_kb[r_len[NB-1:0]] <= i_key_byte;
            end
            r_idx  <= i_sym_index;
            r_type <= i_sym_type;
        end
    end

    // probe and byte counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.probe_init) begin
            r_ptr <= r_hash[SB-1:0];
            r_cnt <= '0;
        end else if (i_cmd.cnt_init) begin
            r_ptr <= '0;
            r_cnt <= '0;
        end else if (i_cmd.cnt_adv) begin
            r_ptr <= r_ptr + SB'(1);
            r_cnt <= r_cnt + SB'(1);
        end
        if (i_cmd.j_clr) begin
            r_j <= '0;
        end else if (i_cmd.j_inc) begin
            r_j <= r_j + NB'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else if (i_cmd.depth_inc) begin
            r_depth <= r_depth + DW'(1);
        end else if (i_cmd.depth_dec) begin
            r_depth <= r_depth - DW'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_found  <= i_cmd.out_found ? w_meta_rdata[19:4] : NO_INDEX;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {5'd0, r_out_found, r_out_status};

    always_comb begin
        o_sts.len_full   = (r_len == LW'(NAME));
        o_sts.depth_zero = (r_depth == '0);
        o_sts.depth_full = (r_depth == DW'(SCOPES));
        o_sts.slot_used  = w_meta_rdata[MW-1];
        o_sts.len_match  = (w_meta_rdata[20 +: LW] == r_len);
        o_sts.len_zero   = (r_len == '0);
        o_sts.byte_match = (w_name_rdata == r_kb[r_j]);
        o_sts.j_last     = ((LW'(r_j) + LW'(1)) == r_len);
        o_sts.cnt_last   = (r_cnt == SB'(SLOTS - 1));
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end
endmodule
`default_nettype wire

@@ rtl/ssht_ctrl.sv @@
`default_nettype none
module ssht_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic [1:0]     i_kind,
    input  wire logic           i_last,
    input  wire ssht_pkg::t_sts i_sts,
    output ssht_pkg::t_cmd      o_cmd
);
    import ssht_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_FIN  = 9'b000000010,
        S_CLR  = 9'b000000100,
        S_RD   = 9'b000001000,
        S_CHK  = 9'b000010000,
        S_CMPR = 9'b000100000,
        S_CMPC = 9'b001000000,
        S_COPY = 9'b010000000,
        S_RESP = 9'b100000000
    } t_state;

    t_state  r_state, n_state;
    logic    r_ins, n_ins;
    logic    r_name, n_name;
    logic    r_found, n_found;
    t_status r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ins   <= 1'b0;
            r_name  <= 1'b0;
            r_found <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_state <= n_state;
            r_ins   <= n_ins;
            r_name  <= n_name;
            r_found <= n_found;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_ins      = r_ins;
        n_name     = r_name;
        n_found    = r_found;
        n_status   = r_status;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (t_kind'(i_kind))
                        K_INSERT, K_LOOKUP: begin
                            o_cmd.key_upd = 1'b1;
                            n_ins = (t_kind'(i_kind) == K_INSERT);
                            if (i_last) begin
                                n_name  = 1'b1;
                                n_state = S_FIN;
                            end
                        end
                        K_PUSH: begin
                            n_name  = 1'b0;
                            n_found = 1'b0;
                            if (i_sts.depth_full) begin
                                n_status = ST_STACK_FULL;
                                n_state  = S_RESP;
                            end else begin
                                o_cmd.cnt_init = 1'b1;
                                n_state = S_CLR;
                            end
                        end
                        default: begin
                            n_name  = 1'b0;
                            n_found = 1'b0;
                            n_state = S_RESP;
                            if (i_sts.depth_zero) begin
                                n_status = ST_STACK_EMPTY;
                            end else begin
                                o_cmd.depth_dec = 1'b1;
                                n_status = ST_OK;
                            end
                        end
                    endcase
                end
            end
            S_FIN: begin
                n_found = 1'b0;
                if (i_sts.len_full) begin
                    n_status = ST_TOO_LONG;
                    n_state  = S_RESP;
                end else if (i_sts.depth_zero) begin
                    n_status = ST_STACK_EMPTY;
                    n_state  = S_RESP;
                end else begin
                    o_cmd.probe_init = 1'b1;
                    n_state = S_RD;
                end
            end
            S_CLR: begin
                o_cmd.meta_clr = 1'b1;
                o_cmd.cnt_adv  = 1'b1;
                if (i_sts.cnt_last) begin
                    o_cmd.depth_inc = 1'b1;
                    n_status = ST_OK;
                    n_state  = S_RESP;
                end
            end
            S_RD: begin
                o_cmd.meta_rd = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (!i_sts.slot_used) begin
                    if (r_ins) begin
                        o_cmd.meta_ins = 1'b1;
                        o_cmd.j_clr    = 1'b1;
                        n_status = ST_OK;
                        n_state  = i_sts.len_zero ? S_RESP : S_COPY;
                    end else begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_RESP;
                    end
                end else if (!r_ins && i_sts.len_match) begin
                    if (i_sts.len_zero) begin
                        n_found  = 1'b1;
                        n_status = ST_OK;
                        n_state  = S_RESP;
                    end else begin
                        o_cmd.j_clr = 1'b1;
                        n_state = S_CMPR;
                    end
                end else if (i_sts.cnt_last) begin
                    n_status = r_ins ? ST_TABLE_FULL : ST_NOT_FOUND;
                    n_state  = S_RESP;
                end else begin
                    o_cmd.cnt_adv = 1'b1;
                    n_state = S_RD;
                end
            end
            S_CMPR: begin
                o_cmd.name_rd = 1'b1;
                n_state = S_CMPC;
            end
            S_CMPC: begin
                if (!i_sts.byte_match) begin
                    if (i_sts.cnt_last) begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_RESP;
                    end else begin
                        o_cmd.cnt_adv = 1'b1;
                        n_state = S_RD;
                    end
                end else if (i_sts.j_last) begin
                    n_found  = 1'b1;
                    n_status = ST_OK;
                    n_state  = S_RESP;
                end else begin
                    o_cmd.j_inc = 1'b1;
                    n_state = S_CMPR;
                end
            end
            S_COPY: begin
                o_cmd.name_wr = 1'b1;
                if (i_sts.j_last) begin
                    n_state = S_RESP;
                end else begin
                    o_cmd.j_inc = 1'b1;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = r_status;
                    o_cmd.out_found  = r_found;
                    o_cmd.key_clr    = r_name;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/scoped_string_hash_table_core.sv @@
`default_nettype none
// steps: pop and a refused push go to S_RESP, a non-final name byte stays in S_IDLE
// (no result for it); a push first clears all SLOTS_PER_TABLE slots in S_CLR; a final
// name byte: S_FIN starts the probe, S_RD and S_CHK per probed slot, S_CMPR and S_CMPC
// per compared byte (lookup) or S_COPY per copied byte (insert); S_RESP loads the result
// throughput: one request in flight, the next one is taken the cycle after its result
// is loaded, which waits while an unread result sits in the output register
// synchronous active-low reset empties the scope stack, resets name length, hash, tvalid
module scoped_string_hash_table_core #(
    parameter int SLOTS_PER_TABLE = ssht_pkg::SLOTS_DEF,
    parameter int MAX_NAME_BYTES  = ssht_pkg::NAME_DEF,
    parameter int MAX_SCOPES      = ssht_pkg::SCOPES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // key_byte, sym_index, sym_type
    input  wire logic [1:0]  s_axis_tuser,  // kind
    input  wire logic        s_axis_tlast,  // final name byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata   // status, found_index
);
    import ssht_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer for probing, comparing, copying and table clearing
    ssht_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready),
        .i_kind    (s_axis_tuser),
        .i_last    (s_axis_tlast),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    // name buffer, hash, slot memories and result register
    ssht_dp #(
        .SLOTS (SLOTS_PER_TABLE),
        .NAME  (MAX_NAME_BYTES),
        .SCOPES(MAX_SCOPES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_key_byte (s_axis_tdata[7:0]),
        .i_sym_index(s_axis_tdata[23:8]),
        .i_sym_type (s_axis_tdata[27:24]),
        .i_out_ready(m_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .o_out_data (m_axis_tdata)
    );
endmodule
`default_nettype wire
